// ----- design/mandelbrot_escape_time_pixel_defines.svh -----
// ============================================================================
// Escape-time pixel unit: assertion macros
// Shared property macros for the checker, clocked on clk and held off
// while rst_n is low.
// ============================================================================
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mbe_pkg.sv -----
// ============================================================================
// Escape-time pixel unit: package
// Shared types, register indexes, reset values, palette and saturation.
// ============================================================================
package mbe_pkg;

    // Fixed-point format and coordinate width
    localparam int FRAC_BITS  = 26;
    localparam int COORD_BITS = 12;
    localparam int ITER_OUT_W = 7;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_STEP   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_RE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_IM    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    localparam logic [30:0] RST_PIXEL_STEP   = 31'd180677;
    localparam logic [31:0] RST_CENTER_RE    = 32'hFE00_0000;
    localparam logic [31:0] RST_CENTER_IM    = 32'h0000_0000;
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1300;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd950;

    // Front-to-back queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [30:0]        pixel_step;
        logic signed [31:0] center_re;
        logic signed [31:0] center_im;
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_col;
        logic [COORD_BITS-1:0] pixel_row;
        logic [ITER_OUT_W-1:0] iterations;
        logic                  inside_res;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
    } result_t;

    // Mapped point handed from the front to the back
    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic signed [31:0]    c_re;
        logic signed [31:0]    c_im;
    } point_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Fixed 16-entry escape palette
    function automatic rgb_t palette(input logic [3:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0:  c = '{8'd66,  8'd30,  8'd15};
            4'd1:  c = '{8'd25,  8'd7,   8'd26};
            4'd2:  c = '{8'd9,   8'd1,   8'd47};
            4'd3:  c = '{8'd4,   8'd4,   8'd73};
            4'd4:  c = '{8'd0,   8'd7,   8'd100};
            4'd5:  c = '{8'd12,  8'd44,  8'd138};
            4'd6:  c = '{8'd24,  8'd82,  8'd177};
            4'd7:  c = '{8'd57,  8'd125, 8'd209};
            4'd8:  c = '{8'd134, 8'd181, 8'd229};
            4'd9:  c = '{8'd211, 8'd236, 8'd248};
            4'd10: c = '{8'd241, 8'd233, 8'd191};
            4'd11: c = '{8'd248, 8'd201, 8'd95};
            4'd12: c = '{8'd255, 8'd170, 8'd0};
            4'd13: c = '{8'd204, 8'd120, 8'd0};
            4'd14: c = '{8'd253, 8'd87,  8'd0};
            default: c = '{8'd106, 8'd52, 8'd3};
        endcase
        return c;
    endfunction

endpackage

// ----- design/mbe_front.sv -----
// ============================================================================
// Escape-time pixel unit: front end
// Accepts a pixel transaction, maps it onto the complex plane (multiply in
// the accept cycle, center add and saturation in the next) and pushes the
// point into the queue.
// ============================================================================
module mbe_front (
    input  logic            clk,
    input  logic            rst_n,
    input  mbe_pkg::cfg_t   cfg,
    input  logic            start,
    input  mbe_pkg::pixel_t pixel,
    output logic            busy,
    output logic            push,
    output mbe_pkg::point_t point,
    input  logic            q_full
);
    import mbe_pkg::*;

    localparam int OFF_W  = COORD_BITS + 2;
    localparam int PROD_W = OFF_W + 32;

    logic                     accept;
    logic                     vld_reg;
    logic                     vld_next;
    logic signed [OFF_W-1:0]  off_re;
    logic signed [OFF_W-1:0]  off_im;
    logic signed [PROD_W-1:0] prod_re_next;
    logic signed [PROD_W-1:0] prod_im_next;
    logic signed [PROD_W-1:0] prod_re_reg;
    logic signed [PROD_W-1:0] prod_im_reg;
    logic signed [PROD_W-1:0] sum_re;
    logic signed [PROD_W-1:0] sum_im;
    logic [COORD_BITS-1:0]    col_reg;
    logic [COORD_BITS-1:0]    row_reg;

    // Stall only when the stage holds a point the queue cannot take
    assign busy   = vld_reg & q_full;
    assign accept = start & ~busy;
    assign push   = vld_reg & ~q_full;

    // Doubled offset from the frame center: 2*pos - size
    assign off_re = $signed({1'b0, pixel.col, 1'b0})
                  - $signed({{(OFF_W-13){1'b0}}, cfg.frame_width});
    assign off_im = $signed({1'b0, pixel.row, 1'b0})
                  - $signed({{(OFF_W-13){1'b0}}, cfg.frame_height});

    assign prod_re_next = PROD_W'(off_re) * PROD_W'($signed({1'b0, cfg.pixel_step}));
    assign prod_im_next = PROD_W'(off_im) * PROD_W'($signed({1'b0, cfg.pixel_step}));

    // Halve (floor), add the center, clamp
    assign sum_re = (prod_re_reg >>> 1) + PROD_W'(cfg.center_re);
    assign sum_im = (prod_im_reg >>> 1) + PROD_W'(cfg.center_im);

    assign point.col  = col_reg;
    assign point.row  = row_reg;
    assign point.c_re = sat32(64'(sum_re));
    assign point.c_im = sat32(64'(sum_im));

    // Hold the stage until the queue takes it
    assign vld_next = accept | (vld_reg & q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg     <= pixel.col;
            row_reg     <= pixel.row;
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

endmodule

// ----- design/mbe_queue.sv -----
// ============================================================================
// Escape-time pixel unit: point queue
// Short FIFO of mapped points between the front end and the iteration engine.
// ============================================================================
module mbe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbe_pkg::point_t wdata,
    output logic            full,
    input  logic            pop,
    output mbe_pkg::point_t rdata,
    output logic            empty
);
    import mbe_pkg::*;

    localparam logic [Q_PTR_W-1:0] LAST_PTR = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_PTR_W:0]   DEPTH_CNT = (Q_PTR_W + 1)'(Q_DEPTH);

    point_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   cnt_reg;
    logic [Q_PTR_W:0]   cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == DEPTH_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the last entry
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/mbe_back.sv -----
// ============================================================================
// Escape-time pixel unit: iteration engine
// Pops a mapped point and iterates z = z^2 + c, each iteration in turn
// registering the three products (ST_MUL), then testing escape and updating z (ST_EVAL).
// ============================================================================
module mbe_back #(
    parameter int MAX_ITER = 100
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  mbe_pkg::point_t  point,
    output logic             pop,
    output logic             done,
    output mbe_pkg::result_t result
);
    import mbe_pkg::*;

    localparam int ITER_W = $clog2(MAX_ITER + 1);
    localparam logic [ITER_W-1:0] MAX_CNT = ITER_W'(MAX_ITER);
    localparam logic [63:0] LIMIT = 64'd16 << (2 * FRAC_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic                  done_reg;
    logic                  done_next;
    logic [ITER_W-1:0]     cnt_reg;
    logic [ITER_W-1:0]     cnt_next;
    logic signed [31:0]    x_reg;
    logic signed [31:0]    x_next;
    logic signed [31:0]    y_reg;
    logic signed [31:0]    y_next;
    logic signed [31:0]    c_re_reg;
    logic signed [31:0]    c_im_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic signed [63:0]    xx_reg;
    logic signed [63:0]    yy_reg;
    logic signed [63:0]    xy_reg;
    logic [63:0]           mag;
    logic                  escape;
    logic                  in_set;
    logic signed [63:0]    re_sum;
    logic signed [63:0]    im_sum;
    logic [ITER_W+ITER_OUT_W-1:0] cnt_wide;
    rgb_t                  color;
    result_t               res_reg;
    result_t               res_next;

    assign pop    = (state_reg == ST_IDLE) & ~q_empty;
    assign done   = done_reg;
    assign result = res_reg;

    // Escape test on the registered squares
    assign mag    = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign in_set = (cnt_reg >= MAX_CNT);
    assign escape = (mag > LIMIT) | in_set;

    // Next z with floor shifts and clamping
    assign re_sum = ((xx_reg - yy_reg) >>> FRAC_BITS) + 64'(c_re_reg);
    assign im_sum = (xy_reg >>> (FRAC_BITS - 1)) + 64'(c_im_reg);

    // Count reported modulo 128, palette by count modulo 16
    assign cnt_wide = {{ITER_OUT_W{1'b0}}, cnt_reg};
    assign color    = palette(cnt_wide[3:0]);

    always_comb
    begin
        res_next.pixel_col  = col_reg;
        res_next.pixel_row  = row_reg;
        res_next.iterations = cnt_wide[ITER_OUT_W-1:0];
        res_next.inside_res = in_set;
        res_next.red        = in_set ? 8'd0 : color.red;
        res_next.green      = in_set ? 8'd0 : color.green;
        res_next.blue       = in_set ? 8'd0 : color.blue;
    end

    // Sequence one point: load, then multiply and evaluate in turn
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    cnt_next   = '0;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (escape)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    x_next     = sat32(re_sum);
                    y_next     = sat32(im_sum);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        if (pop)
        begin
            c_re_reg <= point.c_re;
            c_im_reg <= point.c_im;
            col_reg  <= point.col;
            row_reg  <= point.row;
        end
        if (state_reg == ST_MUL)
        begin
            xx_reg <= 64'(x_reg) * 64'(x_reg);
            yy_reg <= 64'(y_reg) * 64'(y_reg);
            xy_reg <= 64'(x_reg) * 64'(y_reg);
        end
        if (done_next)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- design/mandelbrot_escape_time_pixel.sv -----
// The engine works on one point at a time, popping the next once the last is done;
// each iteration registers the products (ST_MUL), then tests escape and updates z.
// The front end takes a new pixel while the engine works; busy rises when the queue
// is full and the front end still holds a point.
// Results are strobed on done for one cycle and cannot be stalled.
// Reset returns the configuration registers to their defaults and empties the queue.
// ============================================================================
// Escape-time pixel unit: top level
// Configuration registers, front end, point queue and iteration engine.
// ============================================================================
module mandelbrot_escape_time_pixel #(
    parameter int MAX_ITER = 100
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mbe_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              start,
    input  mbe_pkg::pixel_t                   pixel,
    output logic                              busy,
    output logic                              done,
    output mbe_pkg::result_t                  result
);
    import mbe_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    point_t front_point;
    point_t queue_point;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    // Register writes; unused indexes drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PIXEL_STEP:   cfg_next.pixel_step   = cfg_wdata[30:0];
                REG_CENTER_RE:    cfg_next.center_re    = cfg_wdata;
                REG_CENTER_IM:    cfg_next.center_im    = cfg_wdata;
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_wdata[12:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_wdata[12:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_step   <= RST_PIXEL_STEP;
            cfg_reg.center_re    <= RST_CENTER_RE;
            cfg_reg.center_im    <= RST_CENTER_IM;
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mbe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (start),
        .pixel  (pixel),
        .busy   (busy),
        .push   (push),
        .point  (front_point),
        .q_full (q_full)
    );

    mbe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_point),
        .full  (q_full),
        .pop   (pop),
        .rdata (queue_point),
        .empty (q_empty)
    );

    mbe_back #(
        .MAX_ITER (MAX_ITER)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .point   (queue_point),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

// ----- design/mbe_checker.sv -----
// ============================================================================
// Escape-time pixel unit: port checker
// Watches the top-level ports for timing and result consistency; bound to
// the top level below.
// ============================================================================
`include "mandelbrot_escape_time_pixel_defines.svh"

module mbe_checker #(
    parameter int MAX_ITER = 100
) (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input mbe_pkg::result_t result
);
    import mbe_pkg::*;

    localparam logic [ITER_OUT_W-1:0] MAX_ITER_LO = ITER_OUT_W'(MAX_ITER);

    // Results are never strobed in consecutive cycles
    `MBE_ASSERT_NEXT(a_done_spaced, done, !done, "done strobed in consecutive cycles")

    // Busy rises only after a transaction has been taken
    `MBE_ASSERT_NEXT(a_busy_after_accept, !start && !busy, !busy, "busy rose with no transaction")

    // Points in the set are black
    `MBE_ASSERT_SAME(a_inside_black, done && result.inside_res,
        result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0,
        "inside point with nonzero color")

    // Points in the set ran the full iteration budget
    `MBE_ASSERT_SAME(a_inside_count, done && result.inside_res,
        result.iterations == MAX_ITER_LO, "inside point with short iteration count")

endmodule

bind mandelbrot_escape_time_pixel mbe_checker #(
    .MAX_ITER (MAX_ITER)
) u_mbe_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- test/tb_mandelbrot_escape_time_pixel.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Escape-time pixel unit: self-checking testbench
// Feeds pixel coordinates through a random-gap driver and predicts each
// iteration count, inside flag and palette color with a fixed-point model
// of the escape loop. The monitor checks every done strobe against the
// oldest prediction. Register settings are changed only between phases,
// once the unit has drained.
// ============================================================================
module tb_mandelbrot_escape_time_pixel;

    import mbe_pkg::*;

    localparam int unsigned ITER_LIMIT    = 100;
    localparam int unsigned HALF_PERIOD   = 6;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 2 * ITER_LIMIT + 5;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    localparam int unsigned RANDOM_PHASES = 9;
    localparam int unsigned WILD_PHASE    = 4;

    // Unused register slot; writes to it must leave the settings alone
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    // Window of centers that keeps most frames near the set, Q6.26
    localparam int          CRE_LO   = -147639500;
    localparam int unsigned CRE_SPAN = 187904819;
    localparam int          CIM_LO   = -80530637;
    localparam int unsigned CIM_SPAN = 161061274;

    // Escape when |z|^2 exceeds 16 in Q12.52
    localparam logic [63:0] ESCAPE_RADIUS_SQ = 64'd16 << (2 * FRAC_BITS);

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   start     = 1'b0;
    pixel_t                 pixel     = '0;
    logic                   busy;
    logic                   done;
    result_t                result;

    // Shadow copy of the register file
    logic [30:0]            step_q   = RST_PIXEL_STEP;
    logic signed [31:0]     re_mid_q = RST_CENTER_RE;
    logic signed [31:0]     im_mid_q = RST_CENTER_IM;
    logic [12:0]            width_q  = RST_FRAME_WIDTH;
    logic [12:0]            height_q = RST_FRAME_HEIGHT;

    pixel_t                 pixel_backlog[$];
    result_t                predicted_pixels[$];
    int unsigned            gap_left    = 0;
    int unsigned            calm_left   = 0;
    int unsigned            mismatches  = 0;
    int unsigned            cycle_count = 0;

    mandelbrot_escape_time_pixel #(
        .MAX_ITER  (ITER_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .pixel     (pixel),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    // Free-running clock
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Map a pixel index onto the complex plane; the halving floors
    function automatic logic signed [31:0] plane_coord(input logic [11:0] pos,
                                                       input logic [12:0] size,
                                                       input logic signed [31:0] mid);
        logic signed [63:0] twice_off;
        logic signed [63:0] prod;
        twice_off = $signed({51'd0, pos, 1'b0}) - $signed({51'd0, size});
        prod      = twice_off * $signed({33'd0, step_q});
        return clamp32((prod >>> 1) + mid);
    endfunction

    // Escape palette, {red, green, blue}
    function automatic logic [23:0] escape_color(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = {8'd66,  8'd30,  8'd15};
            4'd1:    c = {8'd25,  8'd7,   8'd26};
            4'd2:    c = {8'd9,   8'd1,   8'd47};
            4'd3:    c = {8'd4,   8'd4,   8'd73};
            4'd4:    c = {8'd0,   8'd7,   8'd100};
            4'd5:    c = {8'd12,  8'd44,  8'd138};
            4'd6:    c = {8'd24,  8'd82,  8'd177};
            4'd7:    c = {8'd57,  8'd125, 8'd209};
            4'd8:    c = {8'd134, 8'd181, 8'd229};
            4'd9:    c = {8'd211, 8'd236, 8'd248};
            4'd10:   c = {8'd241, 8'd233, 8'd191};
            4'd11:   c = {8'd248, 8'd201, 8'd95};
            4'd12:   c = {8'd255, 8'd170, 8'd0};
            4'd13:   c = {8'd204, 8'd120, 8'd0};
            4'd14:   c = {8'd253, 8'd87,  8'd0};
            default: c = {8'd106, 8'd52,  8'd3};
        endcase
        return c;
    endfunction

    // Run the escape loop for one pixel under the current settings
    function automatic result_t shade_pixel(input pixel_t p);
        result_t            r;
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] x_next;
        longint             xx;
        longint             yy;
        longint             xy;
        logic [63:0]        mag;
        int unsigned        n;
        logic               escaped;
        c_re    = plane_coord(p.col, width_q, re_mid_q);
        c_im    = plane_coord(p.row, height_q, im_mid_q);
        x       = '0;
        y       = '0;
        n       = 0;
        escaped = 1'b0;
        while (!escaped && n < ITER_LIMIT)
        begin
            xx  = longint'(x) * longint'(x);
            yy  = longint'(y) * longint'(y);
            mag = $unsigned(xx) + $unsigned(yy);
            if (mag > ESCAPE_RADIUS_SQ)
                escaped = 1'b1;
            else
            begin
                xy     = longint'(x) * longint'(y);
                x_next = clamp32(((xx - yy) >>> FRAC_BITS) + longint'(c_re));
                y      = clamp32((xy >>> (FRAC_BITS - 1)) + longint'(c_im));
                x      = x_next;
                n++;
            end
        end
        r.pixel_col  = p.col;
        r.pixel_row  = p.row;
        r.iterations = 7'(n);
        r.inside_res = (n >= ITER_LIMIT);
        if (r.inside_res)
            {r.red, r.green, r.blue} = 24'd0;
        else
            {r.red, r.green, r.blue} = escape_color(4'(n));
        return r;
    endfunction

    // Idle length after a transaction: mostly short, a few long, some calm runs
    function automatic int unsigned pick_gap();
        int unsigned roll;
        int unsigned g;
        roll = $urandom_range(0, 99);
        g    = 0;
        if (calm_left > 0)
            calm_left--;
        else if (roll < 4)
            calm_left = $urandom_range(10, 40);
        else if (roll < 50)
            g = 0;
        else if (roll < 85)
            g = $urandom_range(1, 4);
        else if (roll < 96)
            g = $urandom_range(5, 25);
        else
            g = $urandom_range(40, 150);
        return g;
    endfunction

    // Coordinate inside the frame, now and then anywhere in the field
    function automatic logic [11:0] pick_coord(input logic [12:0] size);
        int unsigned span;
        logic [11:0] v;
        span = (size > 13'd4096) ? 4096 : size;
        if (span == 0 || $urandom_range(0, 9) == 0)
            v = 12'($urandom_range(0, 4095));
        else
            v = 12'($urandom_range(0, span - 1));
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns  mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    task automatic queue_pixel(input logic [11:0] c, input logic [11:0] r);
        pixel_t p;
        p.col = c;
        p.row = r;
        pixel_backlog.push_back(p);
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_PIXEL_STEP:   step_q   = data[30:0];
            REG_CENTER_RE:    re_mid_q = data;
            REG_CENTER_IM:    im_mid_q = data;
            REG_FRAME_WIDTH:  width_q  = data[12:0];
            REG_FRAME_HEIGHT: height_q = data[12:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every queued pixel has been answered, then let the unit rest
    task automatic settle(input int unsigned rest);
        do
            @(negedge clk);
        while (pixel_backlog.size() != 0 || start || predicted_pixels.size() != 0);
        repeat (rest) @(posedge clk);
        @(negedge clk);
    endtask

    // Driver: present pixels from the backlog, hold until accepted
    always @(posedge clk)
    begin : drive_pixels
        logic   nxt_start;
        pixel_t nxt_pixel;
        nxt_start = start;
        nxt_pixel = pixel;
        if (start && !busy)
        begin
            predicted_pixels.push_back(shade_pixel(pixel));
            gap_left = pick_gap();
        end
        if (!start || !busy)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                nxt_start = 1'b0;
            end
            else if (pixel_backlog.size() != 0)
            begin
                nxt_start = 1'b1;
                nxt_pixel = pixel_backlog.pop_front();
            end
            else
                nxt_start = 1'b0;
        end
        start <= nxt_start;
        pixel <= nxt_pixel;
    end

    // Monitor: compare each strobed transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (predicted_pixels.size() == 0)
                flag_mismatch("unexpected result, pixel_col", 32'(result.pixel_col), 32'd0);
            else
            begin
                want = predicted_pixels.pop_front();
                check_field("pixel_col",  32'(result.pixel_col),  32'(want.pixel_col));
                check_field("pixel_row",  32'(result.pixel_row),  32'(want.pixel_row));
                check_field("iterations", 32'(result.iterations), 32'(want.iterations));
                check_field("inside_res", 32'(result.inside_res), 32'(want.inside_res));
                check_field("red",        32'(result.red),        32'(want.red));
                check_field("green",      32'(result.green),      32'(want.green));
                check_field("blue",       32'(result.blue),       32'(want.blue));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : sequencer
        int unsigned phase;
        int unsigned count;
        int unsigned roll;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset view: frame center, cardioid, period-two bulb, edges and corners
        queue_pixel(12'd650,  12'd475);
        queue_pixel(12'd464,  12'd475);
        queue_pixel(12'd835,  12'd475);
        queue_pixel(12'd744,  12'd475);
        queue_pixel(12'd0,    12'd475);
        queue_pixel(12'd650,  12'd100);
        queue_pixel(12'd0,    12'd0);
        queue_pixel(12'd1299, 12'd949);
        queue_pixel(12'd4095, 12'd0);
        queue_pixel(12'd0,    12'd4095);
        queue_pixel(12'd4095, 12'd4095);
        settle(SETTLE_CYCLES);

        // Zero step: every pixel lands on the origin
        write_reg(REG_PIXEL_STEP, 32'd0);
        write_reg(REG_CENTER_RE,  32'd0);
        write_reg(REG_CENTER_IM,  32'd0);
        queue_pixel(12'd0,    12'd0);
        queue_pixel(12'd4095, 12'd4095);
        settle(SETTLE_CYCLES);

        // Widest step with extreme centers: coordinates saturate
        write_reg(REG_PIXEL_STEP, 32'hFFFF_FFFF);
        write_reg(REG_CENTER_RE,  32'h8000_0000);
        write_reg(REG_CENTER_IM,  32'h7FFF_FFFF);
        queue_pixel(12'd0,    12'd0);
        queue_pixel(12'd2048, 12'd2048);
        queue_pixel(12'd4095, 12'd4095);
        settle(SETTLE_CYCLES);

        // Zero width, full height, pixels past the frame
        write_reg(REG_PIXEL_STEP,   {1'b0, RST_PIXEL_STEP});
        write_reg(REG_CENTER_RE,    RST_CENTER_RE);
        write_reg(REG_CENTER_IM,    RST_CENTER_IM);
        write_reg(REG_FRAME_WIDTH,  32'd0);
        write_reg(REG_FRAME_HEIGHT, 32'd4096);
        queue_pixel(12'd0,    12'd0);
        queue_pixel(12'd650,  12'd2048);
        queue_pixel(12'd4095, 12'd0);
        settle(SETTLE_CYCLES);

        // Odd sizes: negative half-pixel offsets floor; spare slot is ignored
        write_reg(REG_FRAME_WIDTH,  32'd8191);
        write_reg(REG_FRAME_HEIGHT, 32'd1);
        write_reg(REG_SPARE,        32'hFFFF_FFFF);
        queue_pixel(12'd4095, 12'd0);
        queue_pixel(12'd4095, 12'd1);
        queue_pixel(12'd3000, 12'd4095);
        settle(SETTLE_CYCLES);

        // Random views near the set, one phase of raw register words
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == WILD_PHASE)
            begin
                write_reg(REG_PIXEL_STEP,   $urandom());
                write_reg(REG_CENTER_RE,    $urandom());
                write_reg(REG_CENTER_IM,    $urandom());
                write_reg(REG_FRAME_WIDTH,  $urandom());
                write_reg(REG_FRAME_HEIGHT, $urandom());
                write_reg(REG_SPARE,        $urandom());
            end
            else
            begin
                roll = $urandom_range(0, 9);
                write_reg(REG_PIXEL_STEP, (roll < 2) ? $urandom_range(1, 3000)
                                                     : $urandom_range(3000, 400000));
                write_reg(REG_CENTER_RE, CRE_LO + $urandom_range(0, CRE_SPAN));
                write_reg(REG_CENTER_IM, CIM_LO + $urandom_range(0, CIM_SPAN));
                roll = $urandom_range(0, 3);
                write_reg(REG_FRAME_WIDTH, (roll == 0) ? $urandom_range(1, 16)
                                                       : $urandom_range(16, 4096));
                roll = $urandom_range(0, 3);
                write_reg(REG_FRAME_HEIGHT, (roll == 0) ? $urandom_range(1, 16)
                                                        : $urandom_range(16, 4096));
            end
            count = $urandom_range(80, 105);
            repeat (count) queue_pixel(pick_coord(width_q), pick_coord(height_q));
            settle(SETTLE_CYCLES);
        end

        // Drain and report
        settle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
